/* design/mts_pkg.sv */
package mts_pkg;

    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CAP_W  = 11;
    localparam int LIM_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int DATA_W = 32;
    localparam int PADDR_W = 3;

    localparam logic [1:0] FUNC_PUSH  = 2'd0;
    localparam logic [1:0] FUNC_POP   = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(1024);

    typedef struct packed {
        logic [1:0]               func;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] min_value;
    } rsp_t;

endpackage

/* design/mts_core.sv */
module mts_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       go,
    input  mts_pkg::req_t              req,
    input  logic [mts_pkg::CAP_W-1:0]  capacity,
    output mts_pkg::rsp_t              rsp
);

    logic signed [mts_pkg::DATA_W-1:0] min_mem [mts_pkg::DEPTH];

    logic [mts_pkg::CNT_W-1:0]         count_reg;
    logic [mts_pkg::CNT_W-1:0]         count_next;
    logic signed [mts_pkg::DATA_W-1:0] top_min_reg;
    logic signed [mts_pkg::DATA_W-1:0] top_min_next;
    logic                              top_sel_ram_reg;
    logic                              top_sel_ram_next;
    logic signed [mts_pkg::DATA_W-1:0] rd_data_reg;

    logic signed [mts_pkg::DATA_W-1:0] top_min;
    logic signed [mts_pkg::DATA_W-1:0] push_min;
    logic [mts_pkg::LIM_W-1:0]         limit;
    logic [mts_pkg::LIM_W-1:0]         count_ext;
    logic                              stack_empty;
    logic                              is_full;
    logic                              push_ok;
    logic                              pop_ok;
    logic [mts_pkg::CNT_W-1:0]         rd_ptr;
    logic [mts_pkg::ADDR_W-1:0]        rd_addr;
    logic [mts_pkg::ADDR_W-1:0]        wr_addr;

    // After a pop the new top minimum comes from the RAM's registered read data.
    assign top_min = top_sel_ram_reg ? rd_data_reg : top_min_reg;

    always_comb
    begin
        if (mts_pkg::LIM_W'(capacity) > mts_pkg::LIM_W'(mts_pkg::DEPTH))
        begin
            limit = mts_pkg::LIM_W'(mts_pkg::DEPTH);
        end
        else
        begin
            limit = mts_pkg::LIM_W'(capacity);
        end
    end

    assign count_ext   = mts_pkg::LIM_W'(count_reg);
    assign stack_empty = (count_reg == '0);
    assign is_full     = (count_ext >= limit);
    assign push_min    = (!stack_empty && (top_min < req.value)) ? top_min : req.value;
    assign push_ok     = go && (req.func == mts_pkg::FUNC_PUSH) && !is_full;
    assign pop_ok      = go && (req.func == mts_pkg::FUNC_POP) && !stack_empty;
    assign wr_addr     = count_reg[mts_pkg::ADDR_W-1:0];
    assign rd_ptr      = count_reg - mts_pkg::CNT_W'(2);
    assign rd_addr     = rd_ptr[mts_pkg::ADDR_W-1:0];

    always_comb
    begin
        rsp.status    = mts_pkg::ST_DONE;
        rsp.min_value = '0;
        case (req.func)
            mts_pkg::FUNC_PUSH:
            begin
                if (is_full)
                begin
                    rsp.status = mts_pkg::ST_FULL;
                end
            end
            mts_pkg::FUNC_POP:
            begin
                if (stack_empty)
                begin
                    rsp.status = mts_pkg::ST_EMPTY;
                end
            end
            mts_pkg::FUNC_QUERY:
            begin
                if (stack_empty)
                begin
                    rsp.status = mts_pkg::ST_EMPTY;
                end
                else
                begin
                    rsp.min_value = top_min;
                end
            end
            default:
            begin
                rsp.status = mts_pkg::ST_DONE;
            end
        endcase
    end

    always_comb
    begin
        count_next       = count_reg;
        top_min_next     = top_min_reg;
        top_sel_ram_next = top_sel_ram_reg;
        if (push_ok)
        begin
            count_next       = count_reg + mts_pkg::CNT_W'(1);
            top_min_next     = push_min;
            top_sel_ram_next = 1'b0;
        end
        else if (pop_ok)
        begin
            count_next       = count_reg - mts_pkg::CNT_W'(1);
            top_sel_ram_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            top_sel_ram_reg <= 1'b0;
        end
        else
        begin
            count_reg       <= count_next;
            top_sel_ram_reg <= top_sel_ram_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_min_reg <= top_min_next;
    end

    // A push writes and a pop reads, never in the same cycle, so the
    // single port pair needs no forwarding.
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            min_mem[wr_addr] <= push_min;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_ok)
        begin
            rd_data_reg <= min_mem[rd_addr];
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= mts_pkg::CNT_W'(mts_pkg::DEPTH))
        else $error("entry count exceeds depth");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        push_ok |=> (count_reg == $past(count_reg) + mts_pkg::CNT_W'(1)))
        else $error("push did not advance the count");

    a_push_top: assert property (@(posedge clk) disable iff (!rst_n)
        push_ok |=> (!top_sel_ram_reg && top_min_reg <= $past(req.value)))
        else $error("top minimum exceeds pushed value");

    a_pop_refill: assert property (@(posedge clk) disable iff (!rst_n)
        pop_ok |=> top_sel_ram_reg)
        else $error("pop did not select the RAM for the new top");
`endif

endmodule

/* design/min_tracking_stack.sv */
// Stack that tracks its running minimum. Each request is a push, a pop or a
// minimum query and yields exactly one response with a status and, for a
// successful query, the current minimum. One request is taken per clock cycle
// unless stalled: the top minimum sits in a register, a push writes the RAM
// without reading it, and a pop refills the top from the RAM's registered read
// port in time for the next request. The response register has a one-entry skid
// behind it, so a request is still taken while one response waits. Pushes
// beyond the capacity register (limited to 1024) are refused with status full.
module min_tracking_stack (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mts_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  mts_pkg::req_t                req,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output mts_pkg::rsp_t                rsp
);

    logic [mts_pkg::CAP_W-1:0] capacity_reg;
    logic                      cap_wr;
    logic                      go;
    logic                      drain;
    mts_pkg::rsp_t             core_rsp;

    logic                      out_valid_reg;
    mts_pkg::rsp_t             out_reg;
    logic                      skid_valid_reg;
    mts_pkg::rsp_t             skid_reg;

    assign pready = 1'b1;
    assign cap_wr = psel && penable && pwrite && !paddr[2];

    always_comb
    begin
        prdata = '0;
        if (!paddr[2])
        begin
            prdata = 32'(capacity_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= mts_pkg::CAPACITY_RESET;
        end
        else if (cap_wr)
        begin
            capacity_reg <= pwdata[mts_pkg::CAP_W-1:0];
        end
    end

    assign req_stall = skid_valid_reg;
    assign go        = req_valid && !skid_valid_reg;
    assign drain     = out_valid_reg && !rsp_stall;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    mts_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (go),
        .req      (req),
        .capacity (capacity_reg),
        .rsp      (core_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (drain)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (go)
        begin
            if (out_valid_reg && !drain)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (drain)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (drain)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (go)
        begin
            if (out_valid_reg && !drain)
            begin
                skid_reg <= core_rsp;
            end
            else
            begin
                out_reg <= core_rsp;
            end
        end
    end

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a response while the output is empty");

    a_skid_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && drain) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid response was not moved to the output");

    a_go_lands: assert property (@(posedge clk) disable iff (!rst_n)
        go |=> out_valid_reg)
        else $error("accepted request left no response");
`endif

endmodule

/* sim/testbench.sv */
module testbench;

    localparam logic [1:0]                  FUNC_IDLE     = 2'd3;
    localparam logic [mts_pkg::PADDR_W-1:0] CAPACITY_ADDR = mts_pkg::PADDR_W'(0);
    localparam int                          RUN_LIMIT     = 400000;
    localparam int                          HOLD_CYCLES   = 200;

    typedef struct {
        bit            bubble;
        bit            drain;
        mts_pkg::req_t item;
    } backlog_t;

    logic                         clk;
    logic                         rst_n     = 1'b0;
    logic                         psel      = 1'b0;
    logic                         penable   = 1'b0;
    logic                         pwrite    = 1'b0;
    logic [mts_pkg::PADDR_W-1:0]  paddr     = '0;
    logic [31:0]                  pwdata    = '0;
    logic [31:0]                  prdata;
    logic                         pready;
    logic                         req_valid = 1'b0;
    logic                         req_stall;
    mts_pkg::req_t                req       = '0;
    logic                         rsp_valid;
    logic                         rsp_stall = 1'b0;
    mts_pkg::rsp_t                rsp;

    // Predicted stack: only the running minimum of each level is kept.
    logic signed [mts_pkg::DATA_W-1:0] level_min [mts_pkg::DEPTH];
    int unsigned                       depth_used  = 0;
    logic [mts_pkg::CAP_W-1:0]         cap_setting = mts_pkg::CAPACITY_RESET;

    backlog_t      req_backlog[$];
    mts_pkg::rsp_t expected_rsp[$];
    int       queued_count   = 0;
    int       accepted_count = 0;
    int       fail_count     = 0;
    int       cycle_count    = 0;
    bit       tx_quiet       = 1'b0;
    bit       rx_quiet       = 1'b0;
    bit       hold_arm       = 1'b0;
    bit       hold_done      = 1'b0;
    int       hold_left      = 0;
    int       rx_wait        = 0;

    min_tracking_stack dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 98)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [mts_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:
            begin
                return 32'h7FFF_FFFF;
            end
            1:
            begin
                return 32'h8000_0000;
            end
            2:
            begin
                return mts_pkg::DATA_W'($urandom_range(0, 16)) - mts_pkg::DATA_W'(8);
            end
            3, 4:
            begin
                return mts_pkg::DATA_W'($urandom_range(0, 2000)) - mts_pkg::DATA_W'(1000);
            end
            default:
            begin
                return $urandom;
            end
        endcase
    endfunction

    function automatic void predict_response(input mts_pkg::req_t r);
        mts_pkg::rsp_t e;
        int unsigned   limit;
        e.status    = mts_pkg::ST_DONE;
        e.min_value = '0;
        limit = (int'(cap_setting) > mts_pkg::DEPTH) ? mts_pkg::DEPTH : int'(cap_setting);
        case (r.func)
            mts_pkg::FUNC_PUSH:
            begin
                if (depth_used >= limit)
                begin
                    e.status = mts_pkg::ST_FULL;
                end
                else
                begin
                    if (depth_used > 0 &&
                        $signed(level_min[depth_used - 1]) < $signed(r.value))
                    begin
                        level_min[depth_used] = level_min[depth_used - 1];
                    end
                    else
                    begin
                        level_min[depth_used] = r.value;
                    end
                    depth_used++;
                end
            end
            mts_pkg::FUNC_POP:
            begin
                if (depth_used == 0)
                begin
                    e.status = mts_pkg::ST_EMPTY;
                end
                else
                begin
                    depth_used--;
                end
            end
            mts_pkg::FUNC_QUERY:
            begin
                if (depth_used == 0)
                begin
                    e.status = mts_pkg::ST_EMPTY;
                end
                else
                begin
                    e.min_value = level_min[depth_used - 1];
                end
            end
            default:
            begin
            end
        endcase
        expected_rsp.push_back(e);
    endfunction

    task automatic queue_req(input logic [1:0] f, input logic [mts_pkg::DATA_W-1:0] v,
                             input bit drain);
        backlog_t    entry;
        int unsigned gap;
        gap = tx_quiet ? 0 : idle_len();
        entry.bubble = 1'b1;
        entry.drain  = 1'b0;
        entry.item   = '0;
        repeat (gap) req_backlog.push_back(entry);
        entry.bubble     = 1'b0;
        entry.drain      = drain;
        entry.item.func  = f;
        entry.item.value = v;
        req_backlog.push_back(entry);
        queued_count++;
    endtask

    task automatic wait_idle();
        while (accepted_count != queued_count || expected_rsp.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(input int unsigned cap);
        wait_idle();
        // A pop may still be refilling the top register from the RAM.
        repeat (4) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAPACITY_ADDR;
        pwdata  <= 32'(cap);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cap_setting = mts_pkg::CAP_W'(cap);
    endtask

    task automatic run_phase(input int unsigned cap, input int n, input int push_pct,
                             input int pop_pct, input bit quiet, input bit with_hold);
        int unsigned r;
        logic [1:0]  f;
        write_capacity(cap);
        tx_quiet = quiet;
        rx_quiet = quiet;
        if (with_hold)
            hold_arm = 1'b1;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                f = FUNC_IDLE;
            else if (r < 3 + push_pct)
                f = mts_pkg::FUNC_PUSH;
            else if (r < 3 + push_pct + pop_pct)
                f = mts_pkg::FUNC_POP;
            else
                f = mts_pkg::FUNC_QUERY;
            queue_req(f, pick_value(), $urandom_range(0, 99) == 0);
        end
    endtask

    // Request driver: presents the backlog in order, leaving req_valid low for each bubble.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                predict_response(req);
                accepted_count++;
            end
            if (!req_valid || !req_stall)
            begin
                if (req_backlog.size() == 0)
                begin
                    req_valid <= 1'b0;
                end
                else if (req_backlog[0].bubble)
                begin
                    void'(req_backlog.pop_front());
                    req_valid <= 1'b0;
                end
                else if (req_backlog[0].drain && expected_rsp.size() != 0)
                begin
                    req_valid <= 1'b0;
                end
                else
                begin
                    req       <= req_backlog[0].item;
                    req_valid <= 1'b1;
                    void'(req_backlog.pop_front());
                end
            end
        end
    end

    // Response stall: random gaps, plus one long hold-off so the block backs up.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else if (hold_arm && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else if (rx_quiet)
        begin
            rsp_stall <= 1'b0;
        end
        else if (rx_wait > 0)
        begin
            rx_wait--;
            rsp_stall <= 1'b1;
        end
        else
        begin
            rx_wait = idle_len();
            rsp_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        mts_pkg::rsp_t e;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected response: status %0d min %0d",
                             rsp.status, rsp.min_value);
            end
            else
            begin
                e = expected_rsp.pop_front();
                if (rsp.status !== e.status || rsp.min_value !== e.min_value)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: expected status %0d min %0d, got status %0d min %0d",
                                 e.status, e.min_value, rsp.status, rsp.min_value);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Empty stack, the unused function code, and the value extremes.
        queue_req(mts_pkg::FUNC_POP,   32'd0,          1'b0);
        queue_req(mts_pkg::FUNC_QUERY, 32'd0,          1'b0);
        queue_req(FUNC_IDLE,           32'hFFFF_FFFF,  1'b0);
        queue_req(mts_pkg::FUNC_PUSH,  32'h7FFF_FFFF,  1'b0);
        queue_req(mts_pkg::FUNC_QUERY, 32'hFFFF_FFFF,  1'b0);
        queue_req(mts_pkg::FUNC_PUSH,  32'h8000_0000,  1'b0);
        queue_req(mts_pkg::FUNC_QUERY, 32'd0,          1'b0);
        queue_req(mts_pkg::FUNC_PUSH,  32'd5,          1'b0);
        queue_req(mts_pkg::FUNC_QUERY, 32'd0,          1'b0);
        queue_req(FUNC_IDLE,           32'd0,          1'b0);
        queue_req(mts_pkg::FUNC_POP,   32'd0,          1'b1);
        queue_req(mts_pkg::FUNC_QUERY, 32'd0,          1'b0);
        queue_req(mts_pkg::FUNC_POP,   32'd0,          1'b0);
        queue_req(mts_pkg::FUNC_QUERY, 32'd0,          1'b0);
        queue_req(mts_pkg::FUNC_POP,   32'd0,          1'b0);
        queue_req(mts_pkg::FUNC_POP,   32'd0,          1'b0);
        queue_req(mts_pkg::FUNC_QUERY, 32'd0,          1'b0);

        // Capacity zero refuses every push; capacity one holds a single entry.
        write_capacity(0);
        queue_req(mts_pkg::FUNC_PUSH,  32'd1,          1'b0);
        queue_req(mts_pkg::FUNC_POP,   32'd0,          1'b0);
        write_capacity(1);
        queue_req(mts_pkg::FUNC_PUSH,  32'd0,          1'b0);
        queue_req(mts_pkg::FUNC_PUSH,  32'hFFFF_FFFF,  1'b0);
        queue_req(mts_pkg::FUNC_QUERY, 32'd0,          1'b0);
        queue_req(mts_pkg::FUNC_POP,   32'd0,          1'b0);

        run_phase(3,    60,   45, 30, 1'b0, 1'b0);
        run_phase(17,   80,   60, 20, 1'b1, 1'b0);
        // Capacity dropped under the current depth: pushes refused until pops catch up.
        run_phase(4,    70,   25, 55, 1'b0, 1'b0);
        run_phase(1024, 90,   40, 30, 1'b1, 1'b1);
        // Capacity above the RAM size, with a long run of pushes that builds a deep stack.
        run_phase(2047, 400,  93, 1,  1'b0, 1'b0);
        run_phase(1025, 40,   40, 30, 1'b0, 1'b0);
        run_phase(0,    25,   40, 40, 1'b0, 1'b0);
        run_phase(2,    40,   45, 35, 1'b0, 1'b0);
        run_phase(1,    25,   50, 30, 1'b0, 1'b0);

        wait_idle();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && expected_rsp.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
